@@ hdl/pfc_pkg.sv @@
// Package for the Playfair digraph cipher core.
// Holds the state type, the action codes, the letter constants and the
// letter folding and default table functions. No dependencies.
package pfc_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [4:0] IDX_I = 5'd8;
    localparam logic [4:0] IDX_J = 5'd9;
    localparam logic [4:0] IDX_Z = 5'd25;
    localparam logic [6:0] ASCII_A = 7'd65;

    localparam logic [2:0] ACT_KEY_BEGIN = 3'd0;
    localparam logic [2:0] ACT_KEY_LETTER = 3'd1;
    localparam logic [2:0] ACT_KEY_END = 3'd2;
    localparam logic [2:0] ACT_TEXT_LETTER = 3'd3;
    localparam logic [2:0] ACT_TEXT_END = 3'd4;

    localparam logic CFG_DECRYPT = 1'b0;
    localparam logic CFG_FILLER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_SQ,
        ST_EMIT1,
        ST_EMIT2
    } t_state;

    // Returns {valid, index}; lower case is folded and J is read as I.
    function automatic logic [5:0] fold_char(input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] idx;
        u = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
        if (u < 8'd65 || u > 8'd90) begin
            return 6'd0;
        end
        idx = 5'(u - 8'd65);
        if (idx == IDX_J) begin
            idx = IDX_I;
        end
        return {1'b1, idx};
    endfunction

    function automatic logic [4:0] filler_index(input logic [6:0] f);
        logic [5:0] r;
        r = fold_char({1'b0, f});
        return r[5] ? r[4:0] : IDX_Z;
    endfunction

    // Square contents after reset: the alphabet with J left out.
    function automatic logic [4:0] default_square(input logic [4:0] q);
        return (q < IDX_J) ? q : q + 5'd1;
    endfunction

    // Letter positions after reset, J sharing the cell of I.
    function automatic logic [4:0] default_pos(input logic [4:0] a);
        if (a < IDX_J) begin
            return a;
        end else if (a == IDX_J) begin
            return IDX_I;
        end
        return a - 5'd1;
    endfunction

endpackage

@@ hdl/pfc_pair_xform.sv @@
// Playfair pair transform: maps the two source cells to the two result cells.
// Depends on pfc_pkg.
module pfc_pair_xform (
    input  logic       i_decrypt,
    input  logic [4:0] i_p1,
    input  logic [4:0] i_p2,
    output logic [4:0] o_q1,
    output logic [4:0] o_q2
);
    import pfc_pkg::*;

    logic [2:0] r1, c1, r2, c2;

    function automatic logic [2:0] wrap_step(input logic [2:0] x, input logic dec);
        logic [3:0] s;
        s = {1'b0, x} + (dec ? 4'd4 : 4'd1);
        return (s >= 4'd5) ? 3'(s - 4'd5) : s[2:0];
    endfunction

    // Row of a cell found by comparing against the row starts.
    function automatic logic [2:0] row_of(input logic [4:0] p);
        if (p >= 5'd20) begin
            return 3'd4;
        end else if (p >= 5'd15) begin
            return 3'd3;
        end else if (p >= 5'd10) begin
            return 3'd2;
        end else if (p >= 5'd5) begin
            return 3'd1;
        end
        return 3'd0;
    endfunction

    function automatic logic [2:0] col_of(input logic [4:0] p, input logic [2:0] r);
        logic [4:0] base;
        base = 5'({2'b00, r} * 5'(SIDE));
        return 3'(p - base);
    endfunction

    function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
        return 5'({2'b00, r} * 5'(SIDE) + {2'b00, c});
    endfunction

    always_comb begin
        r1 = row_of(i_p1);
        c1 = col_of(i_p1, r1);
        r2 = row_of(i_p2);
        c2 = col_of(i_p2, r2);
        if (r1 == r2) begin
            o_q1 = cell_idx(r1, wrap_step(c1, i_decrypt));
            o_q2 = cell_idx(r2, wrap_step(c2, i_decrypt));
        end else if (c1 == c2) begin
            o_q1 = cell_idx(wrap_step(r1, i_decrypt), c1);
            o_q2 = cell_idx(wrap_step(r2, i_decrypt), c2);
        end else begin
            o_q1 = cell_idx(r1, c2);
            o_q2 = cell_idx(r2, c1);
        end
    end

endmodule

@@ hdl/playfair_digraph_cipher_core.sv @@
// Top level of the Playfair digraph cipher core: key schedule, pairing,
// square and position memories and the output word register.
// Depends on pfc_pkg and pfc_pair_xform.
//
// Channel   Dir  Contents
// s_axis    in   tuser[2:0] action, tdata[7:0] character
// m_axis    out  tdata[6:0] out_letter (bit 7 zero), tlast pair_last
// cfg       in   index 0 decrypt_mode, index 1 filler_letter
//
// A key letter, key begin, an ignored item or a text letter that only
// becomes pending is accepted without leaving idle. A text letter that
// completes a pair, or text end with a letter pending, is followed by
// two memory read states (letter positions, then square cells) and two
// output words; each output word holds while the receiver stalls. Key
// end is followed by a walk over the alphabet, one letter per cycle.
// Reset is synchronous and active low; after it the square holds the plain
// alphabet without any clearing pass. A stalled output word holds until taken.
module playfair_digraph_cipher_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    input  logic [2:0] s_axis_tuser,   // [2:0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_letter, [7] zero
    output logic       m_axis_tlast,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data
);
    import pfc_pkg::*;

    t_state r_state, n_state;

    // The square and the letter position table are memories with
    // registered reads. Valid bits say which entries have been written
    // since the last key begin; r_keyed tells whether an unwritten entry
    // reads as the power-up table or as zero.
    logic [4:0] r_sq_mem [CELLS];
    logic [4:0] r_pos_mem [LETTERS];
    logic [CELLS-1:0]   r_sq_vld;
    logic [LETTERS-1:0] r_pos_vld;
    logic               r_keyed;

    logic [LETTERS-1:0] r_used;
    logic [4:0] r_fill;
    logic [4:0] r_sweep;
    logic       r_pend_vld;
    logic [4:0] r_pend;
    logic       r_decrypt;
    logic [6:0] r_filler;

    logic [4:0] r_pa, r_pb;     // letters of the pair in flight
    logic [4:0] r_p1, r_p2;     // their cells
    logic [4:0] r_l1, r_l2;     // result letters

    logic       accept;
    logic [5:0] folded;
    logic       place_en;
    logic [4:0] place_letter;
    logic       pair_go;
    logic [4:0] pair_a, pair_b;
    logic [4:0] q1, q2;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign folded = fold_char(s_axis_tdata);

    pfc_pair_xform u_xform (
        .i_decrypt (r_decrypt),
        .i_p1      (r_p1),
        .i_p2      (r_p2),
        .o_q1      (q1),
        .o_q2      (q2)
    );

    // Pairing and letter placement decisions for the word being accepted or the key end fill sweep.
    always_comb begin
        place_en = 1'b0;
        place_letter = 5'd0;
        pair_go = 1'b0;
        pair_a = r_pend;
        pair_b = folded[4:0];
        if (r_state == ST_FILL) begin
            place_letter = r_sweep;
            place_en = (r_sweep != IDX_J);
        end else if (accept) begin
            case (s_axis_tuser)
                ACT_KEY_LETTER: begin
                    place_letter = folded[4:0];
                    place_en = folded[5];
                end
                ACT_TEXT_LETTER: begin
                    if (folded[5] && r_pend_vld) begin
                        pair_go = 1'b1;
                        if (!r_decrypt && r_pend == folded[4:0]) begin
                            pair_b = filler_index(r_filler);
                        end
                    end
                end
                ACT_TEXT_END: begin
                    pair_go = r_pend_vld;
                    pair_b = filler_index(r_filler);
                end
                default: begin
                end
            endcase
        end
        if (r_fill >= 5'(CELLS) || r_used[place_letter]) begin
            place_en = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && s_axis_tuser == ACT_KEY_END) begin
                    n_state = ST_FILL;
                end else if (pair_go) begin
                    n_state = ST_POS;
                end
            end
            ST_FILL: begin
                if (r_sweep == 5'(LETTERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POS: n_state = ST_SQ;
            ST_SQ: n_state = ST_EMIT1;
            ST_EMIT1: begin
                if (m_axis_tready) begin
                    n_state = ST_EMIT2;
                end
            end
            ST_EMIT2: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_EMIT1) || (r_state == ST_EMIT2);
        m_axis_tlast = (r_state == ST_EMIT2);
        if (r_state != ST_EMIT2) begin
            m_axis_tdata = {1'b0, {2'b00, r_l1} + ASCII_A};
        end else begin
            m_axis_tdata = {1'b0, {2'b00, r_l2} + ASCII_A};
        end
    end

    // Memories: writes while placing letters, reads while looking up a pair.
    always_ff @(posedge i_clk) begin
        if (place_en) begin
            r_sq_mem[r_fill] <= place_letter;
            r_pos_mem[place_letter] <= r_fill;
        end
        if (r_state == ST_POS) begin
            r_p1 <= r_pos_vld[r_pa] ? r_pos_mem[r_pa] :
                    (r_keyed ? 5'd0 : default_pos(r_pa));
            r_p2 <= r_pos_vld[r_pb] ? r_pos_mem[r_pb] :
                    (r_keyed ? 5'd0 : default_pos(r_pb));
        end
        if (r_state == ST_SQ) begin
            r_l1 <= r_sq_vld[q1] ? r_sq_mem[q1] : (r_keyed ? 5'd0 : default_square(q1));
            r_l2 <= r_sq_vld[q2] ? r_sq_mem[q2] : (r_keyed ? 5'd0 : default_square(q2));
        end
        if (pair_go) begin
            r_pa <= pair_a;
            r_pb <= pair_b;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sq_vld <= '0;
            r_pos_vld <= '0;
            r_keyed <= 1'b0;
            r_used <= '0;
            r_fill <= '0;
            r_sweep <= '0;
            r_pend_vld <= 1'b0;
            r_pend <= '0;
            r_decrypt <= 1'b0;
            r_filler <= 7'd90;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DECRYPT) begin
                    r_decrypt <= i_cfg_data[0];
                end else begin
                    r_filler <= i_cfg_data;
                end
            end
            if (place_en) begin
                r_sq_vld[r_fill] <= 1'b1;
                r_pos_vld[place_letter] <= 1'b1;
                r_used[place_letter] <= 1'b1;
                r_fill <= r_fill + 5'd1;
            end
            if (r_state == ST_FILL) begin
                r_sweep <= r_sweep + 5'd1;
            end else begin
                r_sweep <= '0;
            end
            if (accept) begin
                case (s_axis_tuser)
                    ACT_KEY_BEGIN: begin
                        r_sq_vld <= '0;
                        r_pos_vld <= '0;
                        r_keyed <= 1'b1;
                        r_used <= '0;
                        r_fill <= '0;
                        r_pend_vld <= 1'b0;
                        r_pend <= '0;
                    end
                    ACT_TEXT_LETTER: begin
                        if (folded[5]) begin
                            if (!r_pend_vld) begin
                                r_pend_vld <= 1'b1;
                                r_pend <= folded[4:0];
                            end else if (!r_decrypt && r_pend == folded[4:0]) begin
                                r_pend <= folded[4:0];
                            end else begin
                                r_pend_vld <= 1'b0;
                                r_pend <= '0;
                            end
                        end
                    end
                    ACT_TEXT_END: begin
                        r_pend_vld <= 1'b0;
                        r_pend <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench for the Playfair digraph cipher core: a predictor of the square,
// the pairing and the digraph transform, with a scoreboard of output letters.
// Depends on pfc_pkg and the core RTL.
`timescale 1ns / 1ps

class letter_scoreboard;
    logic [6:0] exp_letter[$];
    logic       exp_last[$];
    int         errors;

    function void note_letter(logic [6:0] l, logic last);
        exp_letter.push_back(l);
        exp_last.push_back(last);
    endfunction

    function int pending();
        return exp_letter.size();
    endfunction

    // Returns 0 when the word matches, otherwise a short reason code.
    function int check_word(logic [7:0] data, logic last);
        logic [6:0] l;
        logic       t;
        if (exp_letter.size() == 0) begin
            return 1;
        end
        l = exp_letter.pop_front();
        t = exp_last.pop_front();
        if (data !== {1'b0, l} || last !== t) begin
            return 2;
        end
        return 0;
    endfunction
endclass

module tb_top;
    import pfc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [6:0] i_cfg_data;

    playfair_digraph_cipher_core i_dut (.*);

    // Predictor state: the square, the letter positions and the pairing.
    logic [4:0]  sq_cell[25];
    logic [4:0]  pos_of[26];
    logic [25:0] used;
    int          filled;
    logic        have_pend;
    logic [4:0]  pend;
    logic        dec_mode;
    logic [6:0]  filler;

    letter_scoreboard sb;
    int  fails;
    int  words_out;
    bit  rx_stall_mode;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL playfair_digraph_cipher_core");
        $finish;
    end

    task automatic report(string what);
        fails++;
        $display("mismatch: %s at %0t", what, $realtime);
    endtask

    // Folds a byte to a letter index; returns -1 for a non-letter.
    function automatic int fold(logic [7:0] c);
        int v;
        v = c;
        if (v >= 97 && v <= 122) v -= 32;
        if (v < 65 || v > 90) return -1;
        v -= 65;
        return (v == 9) ? 8 : v;
    endfunction

    function automatic logic [4:0] pad_letter();
        int f;
        f = fold({1'b0, filler});
        return (f < 0) ? 5'd25 : 5'(f);
    endfunction

    task automatic place_letter(logic [4:0] l);
        if (filled >= 25 || used[l]) return;
        sq_cell[filled] = l;
        pos_of[l] = 5'(filled);
        used[l] = 1'b1;
        filled++;
    endtask

    task automatic predict_pair(logic [4:0] a, logic [4:0] b);
        int p1, p2, r1, c1, r2, c2, st, q1, q2;
        p1 = pos_of[a]; p2 = pos_of[b];
        if (p1 >= 25) p1 = 0;
        if (p2 >= 25) p2 = 0;
        r1 = p1 / 5; c1 = p1 % 5; r2 = p2 / 5; c2 = p2 % 5;
        st = dec_mode ? 4 : 1;
        if (r1 == r2) begin
            q1 = r1 * 5 + (c1 + st) % 5;
            q2 = r2 * 5 + (c2 + st) % 5;
        end else if (c1 == c2) begin
            q1 = ((r1 + st) % 5) * 5 + c1;
            q2 = ((r2 + st) % 5) * 5 + c2;
        end else begin
            q1 = r1 * 5 + c2;
            q2 = r2 * 5 + c1;
        end
        sb.note_letter(7'(sq_cell[q1] % 26 + 65), 1'b0);
        sb.note_letter(7'(sq_cell[q2] % 26 + 65), 1'b1);
    endtask

    // Applies one accepted input word to the predictor.
    task automatic predict_word(logic [2:0] act, logic [7:0] ch);
        int l;
        l = fold(ch);
        case (act)
            ACT_KEY_BEGIN: begin
                foreach (sq_cell[k]) sq_cell[k] = '0;
                foreach (pos_of[k]) pos_of[k] = '0;
                used = '0; filled = 0; have_pend = 0; pend = '0;
            end
            ACT_KEY_LETTER: begin
                if (l >= 0) place_letter(5'(l));
            end
            ACT_KEY_END: begin
                for (int k = 0; k < 26; k++) if (k != 9) place_letter(5'(k));
            end
            ACT_TEXT_LETTER: begin
                if (l >= 0) begin
                    if (!have_pend) begin
                        have_pend = 1; pend = 5'(l);
                    end else if (!dec_mode && pend == 5'(l)) begin
                        predict_pair(pend, pad_letter());
                    end else begin
                        predict_pair(pend, 5'(l));
                        have_pend = 0; pend = '0;
                    end
                end
            end
            ACT_TEXT_END: begin
                if (have_pend) begin
                    predict_pair(pend, pad_letter());
                    have_pend = 0; pend = '0;
                end
            end
            default: ;
        endcase
    endtask

    // Receiver: stalls on its own pattern and checks every accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            case (sb.check_word(m_axis_tdata, m_axis_tlast))
                1: report("output word with nothing expected");
                2: report($sformatf("got %h last %b", m_axis_tdata, m_axis_tlast));
                default: ;
            endcase
            words_out++;
        end
        if (rx_stall_mode) m_axis_tready <= ($urandom_range(0, 3) == 0);
        else m_axis_tready <= ($urandom_range(0, 9) != 0);
    end

    // Sends one word and waits for it to be taken.
    task automatic send_word(logic [2:0] act, logic [7:0] ch);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(act, ch);
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Waits until every expected word has come, then lets the core settle.
    task automatic drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DECRYPT) dec_mode = val[0];
        else filler = val;
    endtask

    // Random byte biased toward letters of either case.
    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1, 2, 3: return 8'($urandom_range(97, 122));
            default: return 8'($urandom_range(65, 90));
        endcase
    endfunction

    int sent;
    int burst;

    task automatic paced_send(logic [2:0] act, logic [7:0] ch);
        if (burst == 0) begin
            idle_cycles($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
            burst = $urandom_range(1, 12);
        end
        send_word(act, ch);
        burst--;
        sent++;
    endtask

    initial begin
        logic [6:0] fl;
        int n;
        sb = new();
        fails = 0; words_out = 0; sent = 0; burst = 0;
        rx_stall_mode = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = '0;
        i_rst_n = 0;
        for (int k = 0; k < 25; k++) begin
            sq_cell[k] = 5'(k < 9 ? k : k + 1);
        end
        for (int k = 0; k < 26; k++) pos_of[k] = 5'(k < 9 ? k : (k == 9 ? 8 : k - 1));
        used = '0; filled = 0; have_pend = 0; pend = '0;
        dec_mode = 0; filler = 7'd90;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset square, doubled letters, J, odd tail, junk and unknown actions.
        send_word(ACT_TEXT_LETTER, "A");
        send_word(ACT_TEXT_LETTER, "a");
        send_word(ACT_TEXT_LETTER, "J");
        send_word(ACT_TEXT_LETTER, "i");
        send_word(ACT_TEXT_LETTER, 8'hff);
        send_word(ACT_TEXT_LETTER, "z");
        send_word(ACT_TEXT_END, 8'h00);
        send_word(ACT_TEXT_END, 8'hff);
        send_word(3'd5, "B");
        send_word(3'd6, 8'h55);
        send_word(3'd7, 8'haa);
        // Partial table: text before key end.
        send_word(ACT_KEY_BEGIN, 8'h00);
        send_word(ACT_KEY_LETTER, "k");
        send_word(ACT_TEXT_LETTER, "K");
        send_word(ACT_TEXT_LETTER, "Q");
        send_word(ACT_KEY_LETTER, "E");
        send_word(ACT_KEY_LETTER, "7");
        send_word(ACT_KEY_LETTER, "j");
        send_word(ACT_KEY_END, 8'h00);
        send_word(ACT_KEY_LETTER, "X");
        send_word(ACT_TEXT_LETTER, "H");
        send_word(ACT_TEXT_LETTER, "T");
        send_word(ACT_TEXT_END, 8'h00);
        write_reg(CFG_DECRYPT, 7'd1);
        write_reg(CFG_FILLER, 7'd65);
        send_word(ACT_TEXT_LETTER, "M");
        send_word(ACT_TEXT_LETTER, "M");
        send_word(ACT_TEXT_LETTER, "b");
        send_word(ACT_TEXT_END, 8'h00);
        // Hold off until all words are out.
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            rx_stall_mode = ph[0];
            write_reg(CFG_DECRYPT, 7'(ph[1]));
            case (ph)
                0: fl = 7'd90;
                1: fl = 7'd65;
                2: fl = 7'd74;
                3: fl = 7'd120;
                4: fl = 7'd0;
                5: fl = 7'd127;
                default: fl = 7'($urandom_range(0, 127));
            endcase
            write_reg(CFG_FILLER, fl);
            while (sent < (ph + 1) * 230) begin
                // Mostly a well-formed key followed by text.
                if ($urandom_range(0, 5) != 0) begin
                    paced_send(ACT_KEY_BEGIN, rand_char());
                    n = $urandom_range(0, 30);
                    repeat (n) paced_send(ACT_KEY_LETTER, rand_char());
                    if ($urandom_range(0, 9) != 0) paced_send(ACT_KEY_END, rand_char());
                end
                n = $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) paced_send(ACT_TEXT_LETTER, "L");
                    else paced_send(ACT_TEXT_LETTER, rand_char());
                end
                if ($urandom_range(0, 3) != 0) paced_send(ACT_TEXT_END, rand_char());
                if ($urandom_range(0, 9) == 0) paced_send(3'($urandom_range(0, 7)), rand_char());
            end
        end

        drain();
        if (sb.pending() != 0) begin
            report("expected words never arrived");
        end
        if (fails == 0) begin
            $display("PASS playfair_digraph_cipher_core");
        end else begin
            $display("FAIL playfair_digraph_cipher_core");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/pfc_pkg.sv
hdl/pfc_pair_xform.sv
hdl/playfair_digraph_cipher_core.sv
sim/tb_top.sv
